// ----- hdl/first_fit_block_allocator_assert.svh -----
// Assertion macros for the first-fit block allocator.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH

// same-cycle implication, ignored during reset
`define FFBA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, ignored during reset
`define FFBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/ffba_pkg.sv -----
// Package for the first-fit block allocator: sizes, codes, types.
// No dependencies.
package ffba_pkg;

    localparam int unsigned TABLE_ENTRIES = 1024;
    localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
    localparam int unsigned CNT_W = IDX_W + 1;

    localparam logic [31:0] HEAP_BASE_RESET = 32'd2197152;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic REG_HEAP_BASE    = 1'b0;
    localparam logic REG_MEMORY_LIMIT = 1'b1;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_TABLE_FULL  = 3'd1,
        ST_OUT_OF_MEM  = 3'd2,
        ST_NOT_ALLOC   = 3'd3,
        ST_ALREADY_FREE = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_EVAL,
        S_WR2,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] size;
        logic        free;
    } t_entry;

    localparam int unsigned ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] idx;
        t_entry           data;
    } t_wr;

endpackage

// ----- hdl/ffba_if.sv -----
// Valid/ready channel interfaces for the allocator's request and result items.
// Depends on nothing.
interface ffba_req_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [31:0] request_size;
    logic [31:0] block_address;
    modport source (output valid, func, request_size, block_address, input ready);
    modport sink   (input valid, func, request_size, block_address, output ready);
endinterface

interface ffba_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] granted_address;
    logic [2:0]  status;
    logic        merged;
    modport source (output valid, granted_address, status, merged, input ready);
    modport sink   (input valid, granted_address, status, merged, output ready);
endinterface

// ----- hdl/ffba_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module ffba_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- hdl/first_fit_block_allocator.sv -----
// First-fit block allocator, top level.
// Depends on ffba_pkg, ffba_if.sv, ffba_ram and first_fit_block_allocator_assert.svh.
//
// Usage:
//   i_req carries one item per operation: func (0 allocate, 1 free), request_size
//   and block_address. o_rsp returns one item per request: granted_address,
//   status and merged. Both are valid/ready channels; a transfer happens when
//   valid and ready are high at a rising edge. Registers are written via
//   i_cfg_we / i_cfg_idx / i_cfg_data; the user must write them only while the
//   block is idle (not enforced); writing heap_base also reloads the bump pointer.
//   The descriptor table sits in one RAM (one write, one registered read port).
//   Every operation sweeps the whole table through the read port, one entry
//   per cycle: an allocate sweeps it once (a split adds a second write in
//   S_WR2); a free that reaches the neighbour search sweeps it twice, a
//   rejected free once.
//   One item is in work at a time; i_req.ready is high only when idle.
//   After reset the RAM is cleared one entry per cycle, all TABLE_ENTRIES entries,
//   during which no item is taken (configuration writes are taken).
//   The result sits in an output register; if the receiver stalls, the next
//   item is still taken and worked on, and holds at its end until the
//   register frees.
module first_fit_block_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    ffba_req_if.sink    i_req,
    ffba_rsp_if.source  o_rsp
);
    `include "first_fit_block_allocator_assert.svh"

    localparam logic [ffba_pkg::CNT_W-1:0] CNT_END =
        ffba_pkg::CNT_W'(ffba_pkg::TABLE_ENTRIES);
    localparam logic [ffba_pkg::CNT_W-1:0] CNT_LAST =
        ffba_pkg::CNT_W'(ffba_pkg::TABLE_ENTRIES - 1);

    ffba_pkg::t_state r_state, n_state;

    logic [31:0] r_limit, r_bump;
    logic        r_func;
    logic [31:0] r_req, r_baddr;
    logic        r_phase;

    logic [ffba_pkg::CNT_W-1:0] r_idx;
    logic                       r_rd_vld;
    logic [ffba_pkg::IDX_W-1:0] r_rd_idx;

    logic                       r_fit_ok;
    logic [ffba_pkg::IDX_W-1:0] r_fit_idx;
    ffba_pkg::t_entry           r_fit;
    logic                       r_emp_ok;
    logic [ffba_pkg::IDX_W-1:0] r_emp_idx;
    logic                       r_nb_ok;
    logic [ffba_pkg::IDX_W-1:0] r_nb_idx;
    ffba_pkg::t_entry           r_nb;

    ffba_pkg::t_wr r_w2;
    logic [31:0]   r_res_addr;
    logic [2:0]    r_res_status;
    logic          r_res_merged;

    logic        r_o_valid;
    logic [31:0] r_o_addr;
    logic [2:0]  r_o_status;
    logic        r_o_merged;

    // RAM
    logic                       mem_we;
    logic [ffba_pkg::IDX_W-1:0] mem_waddr;
    ffba_pkg::t_entry           mem_wdata;
    logic [ffba_pkg::ENTRY_W-1:0] mem_rdata_raw;
    ffba_pkg::t_entry           rd;

    logic rd_issue, scan_end, out_free, accept;
    logic touch;

    // evaluation results
    ffba_pkg::t_wr    e_w1, e_w2;
    logic [31:0]      e_addr;
    ffba_pkg::t_status e_status;
    logic             e_merged, e_phase1, e_bump_we;
    logic [32:0]      bump_sum;
    logic [ffba_pkg::IDX_W-1:0] lo_idx, hi_idx;
    ffba_pkg::t_entry lo_ent;
    logic [31:0]      split_addr;

    ffba_ram #(
        .WIDTH(ffba_pkg::ENTRY_W),
        .DEPTH(ffba_pkg::TABLE_ENTRIES)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(r_idx[ffba_pkg::IDX_W-1:0]),
        .o_rdata(mem_rdata_raw)
    );

    assign rd       = ffba_pkg::t_entry'(mem_rdata_raw);
    assign rd_issue = (r_state == ffba_pkg::S_SCAN) && (r_idx != CNT_END);
    assign scan_end = (r_state == ffba_pkg::S_SCAN) && (r_idx == CNT_END) && !r_rd_vld;
    assign out_free = !r_o_valid || o_rsp.ready;
    assign accept   = i_req.valid && i_req.ready;

    // neighbour test against the freed entry
    always_comb begin
        if (r_fit.addr > rd.addr) begin
            touch = (rd.addr + rd.size) == r_fit.addr;
        end else begin
            touch = (r_fit.addr + r_fit.size) == rd.addr;
        end
    end

    // decision once a sweep is over
    always_comb begin
        e_w1      = '0;
        e_w2      = '0;
        e_addr    = '0;
        e_status  = ffba_pkg::ST_OK;
        e_merged  = 1'b0;
        e_phase1  = 1'b0;
        e_bump_we = 1'b0;
        bump_sum  = {1'b0, r_bump} + {1'b0, r_req};
        split_addr = r_fit.addr + r_req;
        if (r_fit.addr < r_nb.addr) begin
            lo_idx = r_fit_idx;
            hi_idx = r_nb_idx;
            lo_ent = r_fit;
        end else begin
            lo_idx = r_nb_idx;
            hi_idx = r_fit_idx;
            lo_ent = r_nb;
        end
        if (r_func == ffba_pkg::FUNC_ALLOC) begin
            if (!r_fit_ok) begin
                if (!r_emp_ok) begin
                    e_status = ffba_pkg::ST_TABLE_FULL;
                end else if (r_bump == 32'd0 || bump_sum[32] ||
                             (r_limit != 32'd0 && bump_sum[31:0] >= r_limit)) begin
                    e_status = ffba_pkg::ST_OUT_OF_MEM;
                end else begin
                    e_bump_we = 1'b1;
                    e_w1.we   = 1'b1;
                    e_w1.idx  = r_emp_idx;
                    e_w1.data = '{addr: r_bump, size: r_req, free: 1'b0};
                    e_addr    = r_bump;
                end
            end else if (r_fit.size != r_req) begin
                if (!r_emp_ok) begin
                    e_status = ffba_pkg::ST_TABLE_FULL;
                end else begin
                    e_w1.we   = 1'b1;
                    e_w1.idx  = r_emp_idx;
                    e_w1.data = '{addr: split_addr, size: r_fit.size - r_req, free: 1'b1};
                    e_w2.we   = 1'b1;
                    e_w2.idx  = r_fit_idx;
                    e_w2.data.addr = (r_emp_idx == r_fit_idx) ? split_addr : r_fit.addr;
                    e_w2.data.size = r_req;
                    e_w2.data.free = 1'b0;
                    e_addr    = e_w2.data.addr;
                end
            end else begin
                e_w1.we   = 1'b1;
                e_w1.idx  = r_fit_idx;
                e_w1.data = '{addr: r_fit.addr, size: r_fit.size, free: 1'b0};
                e_addr    = r_fit.addr;
            end
        end else if (!r_phase) begin
            if (r_baddr == 32'd0 || !r_fit_ok) begin
                e_status = ffba_pkg::ST_NOT_ALLOC;
            end else if (r_fit.free) begin
                e_status = ffba_pkg::ST_ALREADY_FREE;
            end else begin
                e_phase1 = 1'b1;
            end
        end else if (r_nb_ok) begin
            e_merged  = 1'b1;
            e_w1.we   = 1'b1;
            e_w1.idx  = lo_idx;
            e_w1.data = '{addr: lo_ent.addr, size: r_fit.size + r_nb.size, free: 1'b1};
            e_w2.we   = 1'b1;
            e_w2.idx  = hi_idx;
            e_w2.data = '0;
        end else begin
            e_w1.we   = 1'b1;
            e_w1.idx  = r_fit_idx;
            e_w1.data = '{addr: r_fit.addr, size: r_fit.size, free: 1'b1};
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ffba_pkg::S_CLEAR: if (r_idx == CNT_LAST) n_state = ffba_pkg::S_IDLE;
            ffba_pkg::S_IDLE:  if (accept) n_state = ffba_pkg::S_SCAN;
            ffba_pkg::S_SCAN:  if (scan_end) n_state = ffba_pkg::S_EVAL;
            ffba_pkg::S_EVAL: begin
                if (e_phase1) begin
                    n_state = ffba_pkg::S_SCAN;
                end else if (e_w2.we) begin
                    n_state = ffba_pkg::S_WR2;
                end else begin
                    n_state = ffba_pkg::S_DONE;
                end
            end
            ffba_pkg::S_WR2:   n_state = ffba_pkg::S_DONE;
            ffba_pkg::S_DONE:  if (out_free) n_state = ffba_pkg::S_IDLE;
            default:           n_state = ffba_pkg::S_CLEAR;
        endcase
    end

    // state-driven outputs
    always_comb begin
        i_req.ready = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = r_idx[ffba_pkg::IDX_W-1:0];
        mem_wdata   = '0;
        case (r_state)
            ffba_pkg::S_CLEAR: mem_we = 1'b1;
            ffba_pkg::S_IDLE:  i_req.ready = 1'b1;
            ffba_pkg::S_EVAL: begin
                mem_we    = e_w1.we;
                mem_waddr = e_w1.idx;
                mem_wdata = e_w1.data;
            end
            ffba_pkg::S_WR2: begin
                mem_we    = r_w2.we;
                mem_waddr = r_w2.idx;
                mem_wdata = r_w2.data;
            end
            default: mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ffba_pkg::S_CLEAR;
            r_limit   <= '0;
            r_bump    <= ffba_pkg::HEAP_BASE_RESET;
            r_idx     <= '0;
            r_rd_vld  <= 1'b0;
            r_phase   <= 1'b0;
            r_fit_ok  <= 1'b0;
            r_emp_ok  <= 1'b0;
            r_nb_ok   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= rd_issue;
            if (r_state == ffba_pkg::S_CLEAR || rd_issue) begin
                r_idx <= r_idx + 1'b1;
            end
            if (accept) begin
                r_idx    <= '0;
                r_phase  <= 1'b0;
                r_fit_ok <= 1'b0;
                r_emp_ok <= 1'b0;
                r_nb_ok  <= 1'b0;
            end
            if (r_rd_vld) begin
                if (!r_phase) begin
                    if (!r_fit_ok && ((r_func == ffba_pkg::FUNC_ALLOC)
                            ? (rd.free && rd.size >= r_req) : (rd.addr == r_baddr))) begin
                        r_fit_ok <= 1'b1;
                    end
                    if (!r_emp_ok && rd.addr == 32'd0) begin
                        r_emp_ok <= 1'b1;
                    end
                end else if (!r_nb_ok && r_rd_idx != r_fit_idx && rd.free && touch) begin
                    r_nb_ok <= 1'b1;
                end
            end
            if (r_state == ffba_pkg::S_EVAL) begin
                if (e_phase1) begin
                    r_phase <= 1'b1;
                    r_idx   <= '0;
                end
                if (e_bump_we) begin
                    r_bump <= bump_sum[31:0];
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == ffba_pkg::REG_HEAP_BASE) begin
                    r_bump <= i_cfg_data;
                end else if (i_cfg_idx == ffba_pkg::REG_MEMORY_LIMIT) begin
                    r_limit <= i_cfg_data;
                end
            end
            if (r_state == ffba_pkg::S_DONE && out_free) begin
                r_o_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_idx[ffba_pkg::IDX_W-1:0];
        if (accept) begin
            r_func  <= i_req.func;
            r_req   <= i_req.request_size;
            r_baddr <= i_req.block_address;
        end
        if (r_rd_vld) begin
            if (!r_phase) begin
                if (!r_fit_ok && ((r_func == ffba_pkg::FUNC_ALLOC)
                        ? (rd.free && rd.size >= r_req) : (rd.addr == r_baddr))) begin
                    r_fit_idx <= r_rd_idx;
                    r_fit     <= rd;
                end
                if (!r_emp_ok && rd.addr == 32'd0) begin
                    r_emp_idx <= r_rd_idx;
                end
            end else if (!r_nb_ok && r_rd_idx != r_fit_idx && rd.free && touch) begin
                r_nb_idx <= r_rd_idx;
                r_nb     <= rd;
            end
        end
        if (r_state == ffba_pkg::S_EVAL) begin
            r_w2         <= e_w2;
            r_res_addr   <= e_addr;
            r_res_status <= e_status;
            r_res_merged <= e_merged;
        end
        if (r_state == ffba_pkg::S_DONE && out_free) begin
            r_o_addr   <= r_res_addr;
            r_o_status <= r_res_status;
            r_o_merged <= r_res_merged;
        end
    end

    assign o_rsp.valid           = r_o_valid;
    assign o_rsp.granted_address = r_o_addr;
    assign o_rsp.status          = r_o_status;
    assign o_rsp.merged          = r_o_merged;

    `FFBA_ASSERT_NOW(a_no_write_idle, r_state == ffba_pkg::S_IDLE, !mem_we, "table written while idle")
    `FFBA_ASSERT_NOW(a_read_in_scan, r_rd_vld, r_state == ffba_pkg::S_SCAN, "read data outside a sweep")
    `FFBA_ASSERT_NOW(a_merge_ok, o_rsp.valid && o_rsp.merged, o_rsp.status == ffba_pkg::ST_OK, "merge with error status")
    `FFBA_ASSERT_NEXT(a_accept_scan, accept, r_state == ffba_pkg::S_SCAN && r_idx == '0, "item not followed by a sweep")

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for first_fit_block_allocator: directed table, then random items.
// Uses ffba_pkg and the channel interfaces in ffba_if.sv; predicts results not set by a row.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [31:0]       addr;
        ffba_pkg::t_status status;
        logic              merged;
    } t_grant;

    typedef struct {
        bit          is_cfg;
        logic        cfg_reg;
        logic [31:0] cfg_val;
        logic        func;
        logic [31:0] size;
        logic [31:0] baddr;
        bit          typed;
        t_grant      want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_idx = 1'b0;
    logic [31:0] cfg_data = '0;

    ffba_req_if req ();
    ffba_rsp_if rsp ();

    first_fit_block_allocator uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req),
        .o_rsp      (rsp)
    );

    // allocator state as predicted
    logic [31:0] tab_addr [ffba_pkg::TABLE_ENTRIES];
    logic [31:0] tab_size [ffba_pkg::TABLE_ENTRIES];
    bit          tab_free [ffba_pkg::TABLE_ENTRIES];
    logic [31:0] mem_limit_q = '0;
    logic [31:0] bump_q = ffba_pkg::HEAP_BASE_RESET;

    t_grant      grants_due [$];
    logic [31:0] live_blocks [$];
    logic [31:0] freed_blocks [$];
    int          mismatches = 0;
    int          hold_req = 0;
    int          burst_left = 0;

    function automatic int first_empty();
        for (int i = 0; i < ffba_pkg::TABLE_ENTRIES; i++)
            if (tab_addr[i] == 32'd0) return i;
        return -1;
    endfunction

    function automatic t_grant alloc_block(logic [31:0] sz);
        t_grant g;
        int fit;
        int slot;
        logic [31:0] nxt;
        g = '{32'd0, ffba_pkg::ST_OK, 1'b0};
        fit = -1;
        for (int i = 0; i < ffba_pkg::TABLE_ENTRIES; i++)
            if (tab_free[i] && tab_size[i] >= sz) begin
                fit = i;
                break;
            end
        if (fit < 0) begin
            nxt = bump_q + sz;
            slot = first_empty();
            if (slot < 0) begin
                g.status = ffba_pkg::ST_TABLE_FULL;
            end else if (bump_q == 0 || bump_q > nxt
                         || (mem_limit_q != 0 && nxt >= mem_limit_q)) begin
                g.status = ffba_pkg::ST_OUT_OF_MEM;
            end else begin
                tab_addr[slot] = bump_q;
                tab_size[slot] = sz;
                tab_free[slot] = 1'b0;
                g.addr = bump_q;
                bump_q = nxt;
            end
            return g;
        end
        if (tab_size[fit] != sz) begin
            slot = first_empty();
            if (slot < 0) begin
                g.status = ffba_pkg::ST_TABLE_FULL;
                return g;
            end
            tab_addr[slot] = tab_addr[fit] + sz;
            tab_size[slot] = tab_size[fit] - sz;
            tab_free[slot] = 1'b1;
            tab_size[fit] = sz;
        end
        tab_free[fit] = 1'b0;
        g.addr = tab_addr[fit];
        return g;
    endfunction

    function automatic t_grant release_block(logic [31:0] a);
        t_grant g;
        int k;
        int lo;
        int hi;
        bit touch;
        g = '{32'd0, ffba_pkg::ST_OK, 1'b0};
        k = -1;
        if (a == 0) begin
            g.status = ffba_pkg::ST_NOT_ALLOC;
            return g;
        end
        for (int i = 0; i < ffba_pkg::TABLE_ENTRIES; i++)
            if (tab_addr[i] == a) begin
                k = i;
                break;
            end
        if (k < 0) begin
            g.status = ffba_pkg::ST_NOT_ALLOC;
            return g;
        end
        if (tab_free[k]) begin
            g.status = ffba_pkg::ST_ALREADY_FREE;
            return g;
        end
        tab_free[k] = 1'b1;
        for (int i = 0; i < ffba_pkg::TABLE_ENTRIES; i++) begin
            if (i == k || !tab_free[i]) continue;
            if (tab_addr[k] > tab_addr[i])
                touch = (tab_addr[i] + tab_size[i]) == tab_addr[k];
            else
                touch = (tab_addr[k] + tab_size[k]) == tab_addr[i];
            if (touch) begin
                lo = (tab_addr[k] < tab_addr[i]) ? k : i;
                hi = (lo == k) ? i : k;
                tab_size[lo] = tab_size[lo] + tab_size[hi];
                tab_addr[hi] = '0;
                tab_size[hi] = '0;
                tab_free[hi] = 1'b0;
                g.merged = 1'b1;
                break;
            end
        end
        return g;
    endfunction

    function automatic t_grant predict_grant(logic fn, logic [31:0] sz, logic [31:0] a);
        t_grant g;
        if (fn == ffba_pkg::FUNC_ALLOC) begin
            g = alloc_block(sz);
            if (g.status == ffba_pkg::ST_OK) live_blocks.push_back(g.addr);
        end else begin
            g = release_block(a);
            if (g.status == ffba_pkg::ST_OK) freed_blocks.push_back(a);
        end
        return g;
    endfunction

    task automatic offer_item(logic fn, logic [31:0] sz, logic [31:0] a, bit typed,
                              t_grant want);
        int gap;
        bit hs;
        t_grant g;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 10);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end
        burst_left--;
        if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req.valid <= 1'b1;
        req.func <= fn;
        req.request_size <= sz;
        req.block_address <= a;
        do begin
            @(negedge i_clk);
            hs = req.ready;
            @(posedge i_clk);
        end while (!hs);
        g = predict_grant(fn, sz, a);
        grants_due.push_back(typed ? want : g);
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        wait (grants_due.size() == 0);
        repeat (2100) @(posedge i_clk);
    endtask

    task automatic write_reg(logic r, logic [31:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_idx <= r;
        cfg_data <= v;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (r == ffba_pkg::REG_HEAP_BASE) begin
            bump_q = v;
        end else begin
            mem_limit_q = v;
        end
    endtask

    task automatic random_item();
        logic [31:0] sz;
        logic [31:0] a;
        int pick;
        t_grant none;
        none = '{32'd0, ffba_pkg::ST_OK, 1'b0};
        sz = '0;
        a = '0;
        if ($urandom_range(0, 99) < 55) begin
            pick = $urandom_range(0, 15);
            if (pick == 0) sz = $urandom;
            else if (pick < 4) sz = $urandom_range(0, 15);
            else sz = $urandom_range(16, 32'h300);
            offer_item(ffba_pkg::FUNC_ALLOC, sz, $urandom, 1'b0, none);
        end else begin
            pick = $urandom_range(0, 9);
            if (pick < 7 && live_blocks.size() > 0) begin
                pick = $urandom_range(0, live_blocks.size() - 1);
                a = live_blocks[pick];
                live_blocks.delete(pick);
            end else if (pick == 8) begin
                a = '0;
            end else if (pick == 9 && freed_blocks.size() > 0) begin
                a = freed_blocks[$urandom_range(0, freed_blocks.size() - 1)];
            end else begin
                a = $urandom;
            end
            offer_item(ffba_pkg::FUNC_FREE, $urandom, a, 1'b0, none);
        end
    endtask

    t_row rows [$] = '{
        '{0, 0, 0, ffba_pkg::FUNC_ALLOC, 32'd16, 0, 1,
          '{32'h002186A0, ffba_pkg::ST_OK, 1'b0}},
        '{0, 0, 0, ffba_pkg::FUNC_ALLOC, 32'd32, 0, 1,
          '{32'h002186B0, ffba_pkg::ST_OK, 1'b0}},
        '{0, 0, 0, ffba_pkg::FUNC_FREE, 0, 32'd0, 1,
          '{32'd0, ffba_pkg::ST_NOT_ALLOC, 1'b0}},
        '{0, 0, 0, ffba_pkg::FUNC_FREE, 0, 32'h12345, 1,
          '{32'd0, ffba_pkg::ST_NOT_ALLOC, 1'b0}},
        '{0, 0, 0, ffba_pkg::FUNC_FREE, 0, 32'h002186A0, 1,
          '{32'd0, ffba_pkg::ST_OK, 1'b0}},
        '{0, 0, 0, ffba_pkg::FUNC_FREE, 0, 32'h002186A0, 1,
          '{32'd0, ffba_pkg::ST_ALREADY_FREE, 1'b0}},
        '{0, 0, 0, ffba_pkg::FUNC_ALLOC, 32'hFFFFFFFF, 0, 1,
          '{32'd0, ffba_pkg::ST_OUT_OF_MEM, 1'b0}},
        '{0, 0, 0, ffba_pkg::FUNC_ALLOC, 32'd8, 0, 0, '{32'd0, ffba_pkg::ST_OK, 1'b0}},
        '{0, 0, 0, ffba_pkg::FUNC_FREE, 0, 32'h002186B0, 0,
          '{32'd0, ffba_pkg::ST_OK, 1'b0}},
        '{0, 0, 0, ffba_pkg::FUNC_ALLOC, 32'd0, 0, 0, '{32'd0, ffba_pkg::ST_OK, 1'b0}},
        '{0, 0, 0, ffba_pkg::FUNC_ALLOC, 32'd24, 0, 0, '{32'd0, ffba_pkg::ST_OK, 1'b0}},
        '{1, ffba_pkg::REG_MEMORY_LIMIT, 32'hFFFFFFFF, 0, 0, 0, 0,
          '{32'd0, ffba_pkg::ST_OK, 1'b0}},
        '{0, 0, 0, ffba_pkg::FUNC_ALLOC, 32'h7FFF0000, 0, 0,
          '{32'd0, ffba_pkg::ST_OK, 1'b0}},
        '{0, 0, 0, ffba_pkg::FUNC_ALLOC, 32'h80000000, 0, 1,
          '{32'd0, ffba_pkg::ST_OUT_OF_MEM, 1'b0}},
        '{1, ffba_pkg::REG_HEAP_BASE, 32'hFFFFFFFF, 0, 0, 0, 0,
          '{32'd0, ffba_pkg::ST_OK, 1'b0}},
        '{0, 0, 0, ffba_pkg::FUNC_ALLOC, 32'd0, 0, 0, '{32'd0, ffba_pkg::ST_OK, 1'b0}},
        '{0, 0, 0, ffba_pkg::FUNC_ALLOC, 32'd1, 0, 0, '{32'd0, ffba_pkg::ST_OK, 1'b0}},
        '{1, ffba_pkg::REG_MEMORY_LIMIT, 32'h1000, 0, 0, 0, 0,
          '{32'd0, ffba_pkg::ST_OK, 1'b0}},
        '{1, ffba_pkg::REG_HEAP_BASE, 32'd1, 0, 0, 0, 0, '{32'd0, ffba_pkg::ST_OK, 1'b0}},
        '{0, 0, 0, ffba_pkg::FUNC_ALLOC, 32'h800, 0, 0, '{32'd0, ffba_pkg::ST_OK, 1'b0}},
        '{0, 0, 0, ffba_pkg::FUNC_ALLOC, 32'h800, 0, 0, '{32'd0, ffba_pkg::ST_OK, 1'b0}},
        '{0, 0, 0, ffba_pkg::FUNC_FREE, 0, 32'd1, 0, '{32'd0, ffba_pkg::ST_OK, 1'b0}},
        '{1, ffba_pkg::REG_MEMORY_LIMIT, 32'd0, 0, 0, 0, 0,
          '{32'd0, ffba_pkg::ST_OK, 1'b0}}
    };

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("FAIL first_fit_block_allocator");
        $finish;
    end

    // result side: own stall pattern, plus long hold-offs on request
    initial begin
        int hold_left;
        int cyc;
        hold_left = 0;
        cyc = 0;
        rsp.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp.ready <= 1'b0;
            end else if ((cyc / 4000) % 3 == 0) begin
                rsp.ready <= 1'b1;
            end else begin
                rsp.ready <= (cyc % 7) > 2;
            end
        end
    end

    initial begin
        t_grant w;
        forever begin
            @(negedge i_clk);
            if (rsp.valid && rsp.ready) begin
                if (grants_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected item: addr %h status %0d merged %0b",
                                 rsp.granted_address, rsp.status, rsp.merged);
                end else begin
                    w = grants_due.pop_front();
                    if (rsp.granted_address !== w.addr || rsp.status !== w.status
                        || rsp.merged !== w.merged) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %h/%0d/%0b got %h/%0d/%0b",
                                     w.addr, w.status, w.merged, rsp.granted_address,
                                     rsp.status, rsp.merged);
                    end
                end
            end
        end
    end

    initial begin
        req.valid = 1'b0;
        req.func = ffba_pkg::FUNC_ALLOC;
        req.request_size = '0;
        req.block_address = '0;
        for (int i = 0; i < ffba_pkg::TABLE_ENTRIES; i++) begin
            tab_addr[i] = '0;
            tab_size[i] = '0;
            tab_free[i] = 1'b0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[r]) begin
            if (rows[r].is_cfg)
                write_reg(rows[r].cfg_reg, rows[r].cfg_val);
            else
                offer_item(rows[r].func, rows[r].size, rows[r].baddr, rows[r].typed,
                           rows[r].want);
        end

        write_reg(ffba_pkg::REG_HEAP_BASE, 32'h4000);
        write_reg(ffba_pkg::REG_MEMORY_LIMIT, 32'h6000);
        for (int n = 0; n < 97; n++) begin
            if (n == 50) drain();
            random_item();
        end

        write_reg(ffba_pkg::REG_HEAP_BASE, 32'h100000);
        write_reg(ffba_pkg::REG_MEMORY_LIMIT, 32'd0);
        hold_req = 6000;
        for (int n = 0; n < 97; n++) random_item();

        write_reg(ffba_pkg::REG_HEAP_BASE, 32'h7FFFF000);
        write_reg(ffba_pkg::REG_MEMORY_LIMIT, 32'hFFFFFFFF);
        for (int n = 0; n < 96; n++) random_item();

        drain();
        if (mismatches == 0 && grants_due.size() == 0)
            $display("PASS first_fit_block_allocator");
        else
            $display("FAIL first_fit_block_allocator");
        $finish;
    end
endmodule
